// ===== rtl/wena_pkg.sv =====
`default_nettype none
package wena_pkg;

    // field widths of the sample stream
    localparam int SAMPLE_WIDTH    = 32;
    localparam int NORM_WIDTH      = 32;
    localparam int FRAC_BITS       = 16;
    localparam int ACCUM_WIDTH_DEF = 64;

    // one input transfer
    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] reference_value;
        logic signed [SAMPLE_WIDTH-1:0] compared_value;
        logic        [SAMPLE_WIDTH-1:0] cell_volume;
        logic                           last_of_set;
    } t_sample_in;

    // one output transfer
    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] difference;
        logic        [NORM_WIDTH-1:0]   l1_norm;
        logic        [NORM_WIDTH-1:0]   l2_norm;
        logic        [NORM_WIDTH-1:0]   linf_norm;
        logic                           norms_valid;
    } t_norm_out;

endpackage
`default_nettype wire

// ===== rtl/weighted_error_norm_accumulator.sv =====
// Volume-weighted error norm accumulator.
// Input channel: i_in_valid / o_in_stall carry one sample pair, its cell volume
// and a last-of-set flag. Output channel: o_out_valid / i_out_stall carry one
// result per input transfer, in input order.
// Every sample gives its saturated difference. The weighted |d|, d*d and the
// volume are summed in saturating accumulators and the largest |d| is kept.
// A sample that closes a set also returns L1, L2 and Linf and then clears the
// sums for the next set.
// The shared 33x33 multiplier forms the weighted |d| and d*d terms in four
// passes. A closing sample then uses a shared 66-bit subtractor to run a
// 32-step division for L1, a 64-step division and a 32-step square root for
// L2; with a zero volume total these are skipped and L1 and L2 are zero.
// The block takes one sample at a time; o_in_stall is high while it works.
// A finished result sits in an output register, so the next sample is taken
// while the receiver stalls; the block only holds its finished result back
// when the output register is still full.
// Reset (synchronous, active low) clears all sums, the sequencer and the
// output valid.
`default_nettype none
module weighted_error_norm_accumulator #(
    parameter int ACCUM_WIDTH = wena_pkg::ACCUM_WIDTH_DEF
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    output logic                  o_in_stall,
    input  wire wena_pkg::t_sample_in i_in_data,
    output logic                  o_out_valid,
    input  wire                   i_out_stall,
    output wena_pkg::t_norm_out   o_out_data
);
    import wena_pkg::*;

    localparam int AW   = ACCUM_WIDTH;
    localparam int DW   = SAMPLE_WIDTH + 1;
    localparam int PW   = 2 * DW;
    localparam int SUBW = 66;
    localparam logic [AW-1:0] ACC_MAX = '1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_AV,
        S_MUL_AA,
        S_MUL_SL,
        S_MUL_SH,
        S_SQ_TERM,
        S_SQ_ACC,
        S_L1_SET,
        S_L1_DIV,
        S_L2_SET,
        S_L2_DIV,
        S_SQRT,
        S_DONE
    } t_state;

    // saturating accumulate
    function automatic logic [AW-1:0] f_sat_add(input logic [AW-1:0] acc,
                                                input logic [63:0]   x);
        logic [64:0] s;
        s = 65'(acc) + 65'(x);
        if (s > 65'(ACC_MAX)) begin
            return ACC_MAX;
        end
        return s[AW-1:0];
    endfunction

    t_state                  r_state;
    logic [5:0]              r_cnt;
    logic [AW-1:0]           r_abs_sum;
    logic [AW-1:0]           r_sq_sum;
    logic [AW-1:0]           r_vol_total;
    logic [NORM_WIDTH-1:0]   r_max_abs;
    logic [DW-1:0]           r_ad;
    logic [SAMPLE_WIDTH-1:0] r_vol;
    logic [SAMPLE_WIDTH-1:0] r_diff;
    logic                    r_last;
    logic [PW-1:0]           r_prod;
    logic [16:0]             r_sqh;
    logic [63:0]             r_plo;
    logic [63:0]             r_term;
    logic [AW-1:0]           r_rem;
    logic [63:0]             r_shf;
    logic [63:0]             r_quo;
    logic [63:0]             r_x;
    logic [63:0]             r_root;
    logic [63:0]             r_bit;
    logic                    r_sat_l1;
    logic                    r_sat_l2;
    logic [NORM_WIDTH-1:0]   r_l1;
    logic [NORM_WIDTH-1:0]   r_l2;
    logic                    r_out_valid;
    t_norm_out               r_out;

    // difference of the incoming pair
    logic signed [DW-1:0]    w_d;
    logic [DW-1:0]           w_ad;
    logic [SAMPLE_WIDTH-1:0] w_ds;

    always_comb begin
        w_d  = {i_in_data.reference_value[SAMPLE_WIDTH-1], i_in_data.reference_value}
             - {i_in_data.compared_value[SAMPLE_WIDTH-1], i_in_data.compared_value};
        w_ad = w_d[DW-1] ? DW'(-w_d) : DW'(w_d);
        if (w_d[DW-1] != w_d[DW-2]) begin
            w_ds = w_d[DW-1] ? {1'b1, {(SAMPLE_WIDTH-1){1'b0}}}
                             : {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
        end else begin
            w_ds = w_d[SAMPLE_WIDTH-1:0];
        end
    end

    // shared multiplier
    logic [DW-1:0] w_mul_a;
    logic [DW-1:0] w_mul_b;
    logic [PW-1:0] w_mul_p;

    always_comb begin
        unique case (r_state)
            S_MUL_AV: begin
                w_mul_a = r_ad;
                w_mul_b = DW'(r_vol);
            end
            S_MUL_AA: begin
                w_mul_a = r_ad;
                w_mul_b = r_ad;
            end
            S_MUL_SL: begin
                w_mul_a = DW'(r_prod[47:16]);
                w_mul_b = DW'(r_vol);
            end
            S_MUL_SH: begin
                w_mul_a = DW'(r_sqh);
                w_mul_b = DW'(r_vol);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
        w_mul_p = PW'(w_mul_a) * PW'(w_mul_b);
    end

    // square term: floor(sq * vol / 2^32) with the low 16 bits of sq dropped, saturated to 64 bits
    logic [66:0] w_term_sum;
    assign w_term_sum = (67'(r_prod) << 16) + 67'(r_plo[63:16]);

    // shared subtractor for compares, division and square root steps
    logic [SUBW-1:0] w_sub_a;
    logic [SUBW-1:0] w_sub_b;
    logic [SUBW-1:0] w_diff;
    logic            w_ge;

    always_comb begin
        unique case (r_state)
            S_L1_SET: begin
                w_sub_a = SUBW'(r_abs_sum >> 16);
                w_sub_b = SUBW'(r_vol_total);
            end
            S_L2_SET: begin
                w_sub_a = SUBW'(r_sq_sum >> 32);
                w_sub_b = SUBW'(r_vol_total);
            end
            S_L1_DIV, S_L2_DIV: begin
                w_sub_a = SUBW'({r_rem, r_shf[63]});
                w_sub_b = SUBW'(r_vol_total);
            end
            S_SQRT: begin
                w_sub_a = SUBW'(r_x);
                w_sub_b = SUBW'(r_root) + SUBW'(r_bit);
            end
            default: begin
                w_sub_a = '0;
                w_sub_b = '0;
            end
        endcase
        w_diff = w_sub_a - w_sub_b;
        w_ge   = !w_diff[SUBW-1];
    end

    // next quotient and root after one step
    logic [63:0] n_quo;
    logic [63:0] n_root;

    assign n_quo  = {r_quo[62:0], w_ge};
    assign n_root = w_ge ? ((r_root >> 1) + r_bit) : (r_root >> 1);

    logic w_out_free;
    assign w_out_free = !r_out_valid || !i_out_stall;

    // sequencer and datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_abs_sum   <= '0;
            r_sq_sum    <= '0;
            r_vol_total <= '0;
            r_max_abs   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // output register drains independently of the sequencer
            if (r_out_valid && !i_out_stall && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_ad        <= w_ad;
                        r_vol       <= i_in_data.cell_volume;
                        r_diff      <= w_ds;
                        r_last      <= i_in_data.last_of_set;
                        r_vol_total <= f_sat_add(r_vol_total, 64'(i_in_data.cell_volume));
                        if (w_ad[DW-1]) begin
                            r_max_abs <= '1;
                        end else if (w_ad[NORM_WIDTH-1:0] > r_max_abs) begin
                            r_max_abs <= w_ad[NORM_WIDTH-1:0];
                        end
                        r_state <= S_MUL_AV;
                    end
                end
                S_MUL_AV: begin
                    r_prod  <= w_mul_p;
                    r_state <= S_MUL_AA;
                end
                S_MUL_AA: begin
                    r_abs_sum <= f_sat_add(r_abs_sum, 64'(r_prod[PW-1:FRAC_BITS]));
                    r_prod    <= w_mul_p;
                    r_state   <= S_MUL_SL;
                end
                S_MUL_SL: begin
                    r_sqh   <= r_prod[64:48];
                    r_prod  <= w_mul_p;
                    r_state <= S_MUL_SH;
                end
                S_MUL_SH: begin
                    r_plo   <= r_prod[63:0];
                    r_prod  <= w_mul_p;
                    r_state <= S_SQ_TERM;
                end
                S_SQ_TERM: begin
                    r_term  <= (w_term_sum[66:64] != 3'b000) ? '1 : w_term_sum[63:0];
                    r_state <= S_SQ_ACC;
                end
                S_SQ_ACC: begin
                    r_sq_sum <= f_sat_add(r_sq_sum, r_term);
                    r_state  <= r_last ? S_L1_SET : S_DONE;
                end
                // L1 = floor(abs_sum * 2^16 / volume_total)
                S_L1_SET: begin
                    if (r_vol_total == '0) begin
                        r_l1    <= '0;
                        r_l2    <= '0;
                        r_state <= S_DONE;
                    end else begin
                        r_sat_l1 <= w_ge;
                        r_rem    <= r_abs_sum >> 16;
                        r_shf    <= {r_abs_sum[15:0], 48'b0};
                        r_quo    <= '0;
                        r_cnt    <= 6'd31;
                        r_state  <= S_L1_DIV;
                    end
                end
                S_L1_DIV: begin
                    r_rem <= w_ge ? w_diff[AW-1:0] : {r_rem[AW-2:0], r_shf[63]};
                    r_shf <= r_shf << 1;
                    r_quo <= n_quo;
                    r_cnt <= r_cnt - 6'd1;
                    if (r_cnt == '0) begin
                        r_l1    <= r_sat_l1 ? '1 : n_quo[NORM_WIDTH-1:0];
                        r_state <= S_L2_SET;
                    end
                end
                // radicand = floor(square_sum * 2^32 / volume_total)
                S_L2_SET: begin
                    r_sat_l2 <= w_ge;
                    r_rem    <= r_sq_sum >> 32;
                    r_shf    <= {r_sq_sum[31:0], 32'b0};
                    r_quo    <= '0;
                    r_cnt    <= 6'd63;
                    r_state  <= S_L2_DIV;
                end
                S_L2_DIV: begin
                    r_rem <= w_ge ? w_diff[AW-1:0] : {r_rem[AW-2:0], r_shf[63]};
                    r_shf <= r_shf << 1;
                    r_quo <= n_quo;
                    if (r_cnt == '0) begin
                        r_x     <= n_quo;
                        r_root  <= '0;
                        r_bit   <= {2'b01, 62'b0};
                        r_cnt   <= 6'd31;
                        r_state <= S_SQRT;
                    end else begin
                        r_cnt <= r_cnt - 6'd1;
                    end
                end
                // bitwise integer square root, two radicand bits per step
                S_SQRT: begin
                    if (w_ge) begin
                        r_x <= w_diff[63:0];
                    end
                    r_root <= n_root;
                    r_bit  <= r_bit >> 2;
                    r_cnt  <= r_cnt - 6'd1;
                    if (r_cnt == '0) begin
                        r_l2    <= r_sat_l2 ? '1 : n_root[NORM_WIDTH-1:0];
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out_valid       <= 1'b1;
                        r_out.difference  <= r_diff;
                        r_out.l1_norm     <= r_last ? r_l1 : '0;
                        r_out.l2_norm     <= r_last ? r_l2 : '0;
                        r_out.linf_norm   <= r_last ? r_max_abs : '0;
                        r_out.norms_valid <= r_last;
                        if (r_last) begin
                            r_abs_sum   <= '0;
                            r_sq_sum    <= '0;
                            r_vol_total <= '0;
                            r_max_abs   <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire
